[hw/rtl/metaball_pixel_field_unit_defines.svh]
// Shared assertion macros
`ifndef METABALL_PIXEL_FIELD_UNIT_DEFINES_SVH
`define METABALL_PIXEL_FIELD_UNIT_DEFINES_SVH

// same-cycle implication
`define MPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/mpf_pkg.sv]
package mpf_pkg;

    localparam int MAX_BALLS_DEF = 16;

    localparam int COORD_W = 16;
    localparam int D2_W    = 34;
    localparam int ROOT_W  = 17;
    localparam int REM_W   = 20;
    localparam int QUO_W   = 25;
    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 25;

    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_SIZE_GAIN  = 2'd1;
    localparam logic [1:0] REG_BLOB_COUNT = 2'd2;
    localparam logic [1:0] REG_BASE_HUE   = 2'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [D2_W-1:0]   v;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [QUO_W-1:0]  num;
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] den;
        logic [QUO_W-1:0]  quo;
    } dv_t;

endpackage

[hw/rtl/mpf_sqrt_cell.sv]
module mpf_sqrt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  mpf_pkg::sq_t  din,
    output mpf_pkg::sq_t  dout
);

    logic [mpf_pkg::REM_W-1:0] rem_sh;
    logic [mpf_pkg::REM_W-1:0] trial;
    logic                      ge;
    mpf_pkg::sq_t              out_next;
    mpf_pkg::sq_t              out_reg;

    always_comb
    begin
        rem_sh = {din.rem[mpf_pkg::REM_W-3:0], din.v[mpf_pkg::D2_W-1 -: 2]};
        trial  = {1'b0, din.root, 2'b01};
        ge     = (rem_sh >= trial);
        out_next.valid = din.valid;
        out_next.last  = din.last;
        out_next.v     = {din.v[mpf_pkg::D2_W-3:0], 2'b00};
        out_next.rem   = ge ? (rem_sh - trial) : rem_sh;
        out_next.root  = {din.root[mpf_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

[hw/rtl/mpf_div_cell.sv]
module mpf_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  mpf_pkg::dv_t  din,
    output mpf_pkg::dv_t  dout
);

    logic [mpf_pkg::ROOT_W:0] rem_sh;
    logic [mpf_pkg::ROOT_W:0] den_ext;
    logic [mpf_pkg::ROOT_W:0] diff;
    logic                     ge;
    mpf_pkg::dv_t             out_next;
    mpf_pkg::dv_t             out_reg;

    always_comb
    begin
        rem_sh  = {din.rem, din.num[mpf_pkg::QUO_W-1]};
        den_ext = {1'b0, din.den};
        ge      = (rem_sh >= den_ext);
        diff    = rem_sh - den_ext;
        out_next.valid = din.valid;
        out_next.last  = din.last;
        out_next.num   = {din.num[mpf_pkg::QUO_W-2:0], 1'b0};
        out_next.rem   = ge ? diff[mpf_pkg::ROOT_W-1:0] : rem_sh[mpf_pkg::ROOT_W-1:0];
        out_next.den   = din.den;
        out_next.quo   = {din.quo[mpf_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

[hw/rtl/metaball_pixel_field_unit.sv]
// Metaball field evaluator, one pixel per command.
// Commands transfer on start while busy is low. cmd=0 stores a blob centre
// (blob_slot, blob_x, blob_y) at that edge; busy stays low and no result follows.
// cmd=1 evaluates (pixel_col, pixel_row): busy rises, blobs 0..n-1 (n is
// blob_count saturated to MAX_BALLS) stream one per cycle into a chain of 17
// square-root cells and 25 restoring-divide cells, and an accumulator sums the
// reciprocal terms. After scaling, done pulses for one cycle with lit, hue and
// field valid; busy is low in that cycle so the next command may transfer.
// Busy stays high until done, so no new pixel command is taken before then.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at the edge; the
// user must make them only while busy is low, and the block itself does not
// enforce this. The receiver cannot stall: each result is shown exactly once
// in the done cycle. Reset clears control state and loads the register
// defaults; blob table entries are undefined until loaded.
module metaball_pixel_field_unit #(
    parameter int MAX_BALLS = mpf_pkg::MAX_BALLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cmd,
    input  logic [3:0]  blob_slot,
    input  logic [15:0] blob_x,
    input  logic [15:0] blob_y,
    input  logic [7:0]  pixel_col,
    input  logic [7:0]  pixel_row,
    output logic        lit,
    output logic [7:0]  hue,
    output logic [7:0]  field,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
    localparam int CNT_W = $clog2(MAX_BALLS + 1);
    localparam int SUM_W = mpf_pkg::QUO_W + CNT_W;
    localparam int P1_W  = SUM_W + 4;
    localparam int P2_W  = P1_W + 7;
    localparam int CW    = mpf_pkg::COORD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FEED = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [7:0]       thr_reg;
    logic [3:0]       gain_reg;
    logic [4:0]       cnt_cfg_reg;
    logic [7:0]       hue_base_reg;
    logic [CW-1:0]    xt_reg [MAX_BALLS];
    logic [CW-1:0]    yt_reg [MAX_BALLS];
    logic [CW-1:0]    px_reg, py_reg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             feed_last;
    logic             a_valid_reg, a_last_reg;
    logic [CW-1:0]    cx_reg, cy_reg;
    logic             b_valid_reg, b_last_reg;
    logic [CW-1:0]    dx_reg, dy_reg;
    logic             c_valid_reg, c_last_reg;
    logic [2*CW-1:0]  sqx_reg, sqy_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [P1_W-1:0]  p1_reg;
    logic [P2_W-1:0]  p2;
    logic [7:0]       fclamp, fthr;
    logic             done_reg, lit_reg;
    logic [7:0]       hue_reg, field_reg;
    logic             accept, load_ok;
    logic [6:0]       slot_ext;
    logic [CNT_W-1:0] n_sat;

    mpf_pkg::sq_t sq_chain [mpf_pkg::SQRT_STEPS+1];
    mpf_pkg::dv_t dv_chain [mpf_pkg::DIV_STEPS+1];

    assign accept   = start && !busy;
    assign slot_ext = {3'b000, blob_slot};
    assign load_ok  = accept && (cmd == mpf_pkg::CMD_LOAD) && (slot_ext < 7'(MAX_BALLS));
    assign n_sat    = ({2'b00, cnt_cfg_reg} > 7'(MAX_BALLS)) ? CNT_W'(MAX_BALLS)
                                                              : CNT_W'(cnt_cfg_reg);
    assign feed_last = (CNT_W'(idx_reg) == (n_reg - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= 8'd128;
            gain_reg     <= 4'd5;
            cnt_cfg_reg  <= 5'd2;
            hue_base_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpf_pkg::REG_THRESHOLD:  thr_reg      <= cfg_data;
                mpf_pkg::REG_SIZE_GAIN:  gain_reg     <= cfg_data[3:0];
                mpf_pkg::REG_BLOB_COUNT: cnt_cfg_reg  <= cfg_data[4:0];
                mpf_pkg::REG_BASE_HUE:   hue_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            xt_reg[slot_ext[IDX_W-1:0]] <= blob_x;
            yt_reg[slot_ext[IDX_W-1:0]] <= blob_y;
        end
        cx_reg <= xt_reg[idx_reg];
        cy_reg <= yt_reg[idx_reg];
        dx_reg <= (cx_reg >= px_reg) ? (cx_reg - px_reg) : (px_reg - cx_reg);
        dy_reg <= (cy_reg >= py_reg) ? (cy_reg - py_reg) : (py_reg - cy_reg);
        sqx_reg <= {{CW{1'b0}}, dx_reg} * {{CW{1'b0}}, dx_reg};
        sqy_reg <= {{CW{1'b0}}, dy_reg} * {{CW{1'b0}}, dy_reg};
        if (accept && (cmd == mpf_pkg::CMD_PIXEL))
        begin
            px_reg <= {pixel_col, 8'd0};
            py_reg <= {pixel_row, 8'd0};
            n_reg  <= n_sat;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && (cmd == mpf_pkg::CMD_PIXEL))
                    state_next = (n_sat == '0) ? S_MUL1 : S_FEED;
            S_FEED:
                if (feed_last)
                    state_next = S_WAIT;
            S_WAIT:
                if (dv_chain[mpf_pkg::DIV_STEPS].valid && dv_chain[mpf_pkg::DIV_STEPS].last)
                    state_next = S_MUL1;
            S_MUL1:
                state_next = S_MUL2;
            S_MUL2:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
            c_valid_reg <= 1'b0;
            c_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_valid_reg <= (state_reg == S_FEED);
            a_last_reg  <= (state_reg == S_FEED) && feed_last;
            b_valid_reg <= a_valid_reg;
            b_last_reg  <= a_last_reg;
            c_valid_reg <= b_valid_reg;
            c_last_reg  <= b_last_reg;
            done_reg    <= (state_reg == S_MUL2);
            if (state_reg == S_FEED)
                idx_reg <= idx_reg + IDX_W'(1);
            else
                idx_reg <= '0;
        end
    end

    always_comb
    begin
        sq_chain[0].valid = c_valid_reg;
        sq_chain[0].last  = c_last_reg;
        sq_chain[0].v     = {2'b00, sqx_reg} + {2'b00, sqy_reg};
        sq_chain[0].rem   = '0;
        sq_chain[0].root  = '0;
        dv_chain[0].valid = sq_chain[mpf_pkg::SQRT_STEPS].valid;
        dv_chain[0].last  = sq_chain[mpf_pkg::SQRT_STEPS].last;
        dv_chain[0].num   = {1'b1, {(mpf_pkg::QUO_W-1){1'b0}}};
        dv_chain[0].rem   = '0;
        dv_chain[0].den   = (sq_chain[mpf_pkg::SQRT_STEPS].root == '0)
                            ? mpf_pkg::ROOT_W'(1) : sq_chain[mpf_pkg::SQRT_STEPS].root;
        dv_chain[0].quo   = '0;
    end

    for (genvar k = 0; k < mpf_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        mpf_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (sq_chain[k]),
            .dout (sq_chain[k+1])
        );
    end

    for (genvar k = 0; k < mpf_pkg::DIV_STEPS; k++)
    begin : g_div
        mpf_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (dv_chain[k]),
            .dout (dv_chain[k+1])
        );
    end

    assign p2     = P2_W'(p1_reg) * P2_W'(100);
    assign fclamp = (|p2[P2_W-1:24]) ? 8'd255 : p2[23:16];
    assign fthr   = (fclamp < thr_reg) ? 8'd0 : fclamp;

    always_ff @(posedge clk)
    begin
        if (accept)
            sum_reg <= '0;
        else if (dv_chain[mpf_pkg::DIV_STEPS].valid)
            sum_reg <= sum_reg + SUM_W'(dv_chain[mpf_pkg::DIV_STEPS].quo);
        if (state_reg == S_MUL1)
            p1_reg <= P1_W'(sum_reg) * P1_W'(gain_reg);
        if (state_reg == S_MUL2)
        begin
            field_reg <= fthr;
            lit_reg   <= (fthr > thr_reg);
            hue_reg   <= 8'd255 - fthr + hue_base_reg;
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign lit   = lit_reg;
    assign hue   = hue_reg;
    assign field = field_reg;

endmodule

[hw/rtl/mpf_checker.sv]
`include "metaball_pixel_field_unit_defines.svh"

module mpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       cmd,
    input logic       lit,
    input logic [7:0] field
);

    `MPF_ASSERT_NOW(a_done_not_busy, done, !busy)
    `MPF_ASSERT_NOW(a_done_after_busy, done, $past(busy))
    `MPF_ASSERT_NEXT(a_load_no_wait, start && !busy && (cmd == mpf_pkg::CMD_LOAD), !busy && !done)
    `MPF_ASSERT_NOW(a_dark_when_zero, done && (field == 8'd0), !lit)

endmodule

bind metaball_pixel_field_unit mpf_checker u_mpf_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .lit  (lit),
    .field(field)
);
